FILE: hdl/tf512_pkg.sv
// Shared types, constants and round functions for the Threefish-512 block cipher.
`default_nettype none
package tf512_pkg;

  localparam int unsigned NumWords   = 8;
  localparam int unsigned NumRounds  = 72;
  localparam int unsigned NumSubkeys = NumRounds / 4 + 1;
  localparam int unsigned NumGroups  = NumRounds / 4;
  localparam logic [63:0] KeyParity  = 64'h1BD1_1BDA_A9FC_1A22;

  typedef logic [63:0] word_t;
  typedef word_t [NumWords-1:0] block_t;
  typedef word_t [NumWords:0] ext_key_t;
  typedef logic [2:0] key_idx_t;

  typedef enum logic {
    FuncEncrypt = 1'b0,
    FuncDecrypt = 1'b1
  } func_e;

  typedef logic [5:0] rot_t;
  typedef rot_t [3:0] rot_row_t;

  localparam rot_row_t [7:0] RotTab = '{
    '{6'd22, 6'd56, 6'd35, 6'd8},
    '{6'd43, 6'd39, 6'd29, 6'd25},
    '{6'd17, 6'd10, 6'd50, 6'd13},
    '{6'd24, 6'd34, 6'd30, 6'd39},
    '{6'd56, 6'd54, 6'd9,  6'd44},
    '{6'd39, 6'd36, 6'd49, 6'd17},
    '{6'd42, 6'd14, 6'd27, 6'd33},
    '{6'd37, 6'd19, 6'd36, 6'd46}
  };

  localparam logic [2:0] PermTab [NumWords] = '{3'd2, 3'd1, 3'd4, 3'd7,
                                                3'd6, 3'd5, 3'd0, 3'd3};

  function automatic word_t rotl(word_t x, rot_t r);
    rotl = (x << r) | (x >> (7'd64 - {1'b0, r}));
  endfunction

  function automatic word_t rotr(word_t x, rot_t r);
    rotr = (x >> r) | (x << (7'd64 - {1'b0, r}));
  endfunction

  // Word j of subkey s, with the subkey number added into the last word.
  // The key word index s + j stays below 27, so two compares reduce it modulo 9.
  function automatic word_t subkey_word(ext_key_t ks, int unsigned s, int unsigned j);
    word_t w;
    logic [4:0] idx;
    idx = 5'(s + j);
    if (idx >= 5'd18) idx = idx - 5'd18;
    else if (idx >= 5'd9) idx = idx - 5'd9;
    w = ks[idx[3:0]];
    if (j == NumWords - 1) w = w + word_t'(s);
    subkey_word = w;
  endfunction

  function automatic block_t add_subkey(block_t v, ext_key_t ks, int unsigned s);
    block_t r;
    for (int unsigned j = 0; j < NumWords; j++) r[j] = v[j] + subkey_word(ks, s, j);
    add_subkey = r;
  endfunction

  function automatic block_t sub_subkey(block_t v, ext_key_t ks, int unsigned s);
    block_t r;
    for (int unsigned j = 0; j < NumWords; j++) r[j] = v[j] - subkey_word(ks, s, j);
    sub_subkey = r;
  endfunction

  function automatic block_t enc_round(block_t v, int unsigned d);
    block_t m;
    block_t r;
    for (int unsigned j = 0; j < 4; j++) begin
      m[2*j]   = v[2*j] + v[2*j+1];
      m[2*j+1] = rotl(v[2*j+1], RotTab[d % 8][j]) ^ m[2*j];
    end
    for (int unsigned j = 0; j < NumWords; j++) r[j] = m[PermTab[j]];
    enc_round = r;
  endfunction

  function automatic block_t dec_round(block_t v, int unsigned d);
    block_t t;
    block_t r;
    for (int unsigned j = 0; j < NumWords; j++) t[PermTab[j]] = v[j];
    for (int unsigned j = 0; j < 4; j++) begin
      r[2*j+1] = rotr(t[2*j+1] ^ t[2*j], RotTab[d % 8][j]);
      r[2*j]   = t[2*j] - r[2*j+1];
    end
    dec_round = r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/threefish512_block_cipher.sv
// Top level of the pipelined Threefish-512 block cipher with a zero tweak.
`default_nettype none
// Usage: load the eight key words through cfg_we_i / cfg_idx_i / cfg_data_i
// while no request is in flight; a write to index 8 or above is ignored.
// A request is taken at a rising edge with start_i high and busy_o low; busy_o
// is always low, so a new block may enter in every cycle. func_i selects
// encryption (0) or decryption (1) per block.
// The 72 rounds are unrolled into 18 register stages of four rounds each, plus
// an input stage and an output stage; a result passes through the input stage,
// the round stages and the output stage, and appears on the outputs with
// done_o high for exactly one cycle, one result per cycle at full rate.
// Each round stage does four rounds and one subkey add or subtract, the first
// also taking off the final subkey in decryption; encryption and decryption
// run through the same stages, one path chosen per block by its func bit.
// Reset clears the valid bits and the key to zero; results cannot be held
// off by the receiver, and none is lost or repeated.
module threefish512_block_cipher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        func_i,
  input  wire logic [63:0] text_word_0_i,
  input  wire logic [63:0] text_word_1_i,
  input  wire logic [63:0] text_word_2_i,
  input  wire logic [63:0] text_word_3_i,
  input  wire logic [63:0] text_word_4_i,
  input  wire logic [63:0] text_word_5_i,
  input  wire logic [63:0] text_word_6_i,
  input  wire logic [63:0] text_word_7_i,
  output logic             done_o,
  output logic [63:0]      out_word_0_o,
  output logic [63:0]      out_word_1_o,
  output logic [63:0]      out_word_2_o,
  output logic [63:0]      out_word_3_o,
  output logic [63:0]      out_word_4_o,
  output logic [63:0]      out_word_5_o,
  output logic [63:0]      out_word_6_o,
  output logic [63:0]      out_word_7_o
);

  localparam int unsigned NG = tf512_pkg::NumGroups;
  localparam int unsigned NW = tf512_pkg::NumWords;
  localparam int unsigned NS = tf512_pkg::NumSubkeys;

  tf512_pkg::word_t    key_q [NW];
  tf512_pkg::ext_key_t ks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NW; i++) key_q[i] <= '0;
    end else if (cfg_we_i && (cfg_idx_i[3] == 1'b0)) begin
      key_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    ks[NW] = tf512_pkg::KeyParity;
    for (int unsigned i = 0; i < NW; i++) begin
      ks[i]  = key_q[i];
      ks[NW] = ks[NW] ^ key_q[i];
    end
  end

  assign busy_o = 1'b0;

  // Stage 0 holds the request; stage g+1 holds the block after group g.
  logic                valid_q [NG+1];
  logic                func_q  [NG+1];
  tf512_pkg::block_t   data_q  [NG+1];
  logic                done_q;
  tf512_pkg::block_t   res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i <= NG; i++) valid_q[i] <= 1'b0;
      done_q <= 1'b0;
    end else begin
      valid_q[0] <= start_i;
      for (int unsigned i = 1; i <= NG; i++) valid_q[i] <= valid_q[i-1];
      done_q <= valid_q[NG];
    end
  end

  always_ff @(posedge clk_i) begin
    func_q[0] <= func_i;
    data_q[0] <= {text_word_7_i, text_word_6_i, text_word_5_i, text_word_4_i,
                  text_word_3_i, text_word_2_i, text_word_1_i, text_word_0_i};
  end

  for (genvar g = 0; g < NG; g++) begin : g_grp
    // Decryption walks the groups in reverse; group g of the pipe handles
    // original group NG-1-g, and the final-subkey removal sits in group 0.
    tf512_pkg::block_t enc_v, dec_v;
    always_comb begin
      enc_v = tf512_pkg::add_subkey(data_q[g], ks, g);
      for (int unsigned r = 0; r < 4; r++) enc_v = tf512_pkg::enc_round(enc_v, 4*g + r);
      dec_v = data_q[g];
      if (g == 0) dec_v = tf512_pkg::sub_subkey(dec_v, ks, NS - 1);
      for (int unsigned r = 0; r < 4; r++)
        dec_v = tf512_pkg::dec_round(dec_v, 4*(NG-1-g) + 3 - r);
      dec_v = tf512_pkg::sub_subkey(dec_v, ks, NG - 1 - g);
    end
    always_ff @(posedge clk_i) begin
      func_q[g+1] <= func_q[g];
      data_q[g+1] <= (func_q[g] == tf512_pkg::FuncDecrypt) ? dec_v : enc_v;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= (func_q[NG] == tf512_pkg::FuncDecrypt) ? data_q[NG]
           : tf512_pkg::add_subkey(data_q[NG], ks, NS - 1);
  end

  assign done_o       = done_q;
  assign out_word_0_o = res_q[0];
  assign out_word_1_o = res_q[1];
  assign out_word_2_o = res_q[2];
  assign out_word_3_o = res_q[3];
  assign out_word_4_o = res_q[4];
  assign out_word_5_o = res_q[5];
  assign out_word_6_o = res_q[6];
  assign out_word_7_o = res_q[7];

endmodule
`default_nettype wire
